// ----- rtl/core/cac_pkg.sv -----
// Shared types and constants for the cry alarm controller.
// No dependencies; every other file in rtl/core imports this package.
package cac_pkg;

  // Controller state, also shown on the status output
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DETECT = 2'd1,
    ST_ALARM  = 2'd2
  } state_e;

  // Key codes carried by each poll
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_ENTER = 3'd1;
  localparam logic [2:0] OP_BACK  = 3'd2;
  localparam logic [2:0] OP_UP    = 3'd3;
  localparam logic [2:0] OP_DOWN  = 3'd4;

  // Notice codes
  localparam logic [2:0] NTC_NONE       = 3'd0;
  localparam logic [2:0] NTC_MODE_SOUND = 3'd1;
  localparam logic [2:0] NTC_MODE_MUTE  = 3'd2;
  localparam logic [2:0] NTC_CLEARED    = 3'd3;
  localparam logic [2:0] NTC_AUTO_STOP  = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_FLOOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_CEIL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_INCR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DET_TMO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_DUR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PER = 3'd6;

  // Field widths fixed by the register map
  localparam int unsigned THR_W = 12;
  localparam int unsigned TMO_W = 16;
  localparam int unsigned DUR_W = 20;
  localparam int unsigned BLK_W = 16;

  // Reset values
  localparam logic [THR_W-1:0] RST_INIT_THR  = 12'd2000;
  localparam logic [THR_W-1:0] RST_THR_FLOOR = 12'd500;
  localparam logic [THR_W-1:0] RST_THR_CEIL  = 12'd3500;
  localparam logic [THR_W-1:0] RST_THR_INCR  = 12'd200;
  localparam logic [TMO_W-1:0] RST_DET_TMO   = 16'd3000;
  localparam logic [DUR_W-1:0] RST_ALARM_DUR = 20'd30000;
  localparam logic [BLK_W-1:0] RST_BLINK_PER = 16'd500;

  // Settings seen by the controller step
  typedef struct packed {
    logic [THR_W-1:0] thr_floor;
    logic [THR_W-1:0] thr_ceil;
    logic [THR_W-1:0] thr_incr;
    logic [TMO_W-1:0] det_tmo;
    logic [DUR_W-1:0] alarm_dur;
    logic [BLK_W-1:0] blink_per;
  } cac_cfg_t;

endpackage

// ----- rtl/core/cac_cfg_regs.sv -----
// Configuration register bank of the cry alarm controller.
// Depends on cac_pkg; the initial threshold is loaded straight into the top level.
module cac_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cac_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cac_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output cac_pkg::cac_cfg_t                 cfg_o
);
  import cac_pkg::*;

  cac_cfg_t cfg_q;

  // Decode the write and keep each field at its own width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr_floor <= RST_THR_FLOOR;
      cfg_q.thr_ceil  <= RST_THR_CEIL;
      cfg_q.thr_incr  <= RST_THR_INCR;
      cfg_q.det_tmo   <= RST_DET_TMO;
      cfg_q.alarm_dur <= RST_ALARM_DUR;
      cfg_q.blink_per <= RST_BLINK_PER;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_THR_FLOOR: cfg_q.thr_floor <= cfg_wdata_i[THR_W-1:0];
        REG_THR_CEIL:  cfg_q.thr_ceil  <= cfg_wdata_i[THR_W-1:0];
        REG_THR_INCR:  cfg_q.thr_incr  <= cfg_wdata_i[THR_W-1:0];
        REG_DET_TMO:   cfg_q.det_tmo   <= cfg_wdata_i[TMO_W-1:0];
        REG_ALARM_DUR: cfg_q.alarm_dur <= cfg_wdata_i[DUR_W-1:0];
        REG_BLINK_PER: cfg_q.blink_per <= cfg_wdata_i[BLK_W-1:0];
        default: begin
          // initial threshold lives in the top level; index 7 is unused
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/cry_alarm_controller.sv -----
// Cry alarm controller top level: input register, one-poll step logic, result register.
// Depends on cac_pkg and cac_cfg_regs.
//
// One poll is accepted per clock cycle while in_stall_o is low; its result is loaded into
// the output register when the output side is ready. The whole step (key handling, threshold
// clamp, state update, wrap-around time compares) is a single layer of logic between the
// input register and the controller state, so the rate is one poll per cycle whenever the
// output side is not stalled. A stalled valid result holds the result register; a poll in
// the input register then holds too and raises in_stall_o. Configuration writes take effect
// on the next edge; writing the initial threshold also loads the live threshold.
module cry_alarm_controller #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // poll requests
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     opcode_i,
  input  logic [TIME_BITS-1:0]           now_ms_i,
  input  logic [SAMPLE_BITS-1:0]         sound_level_i,
  input  logic                           sound_trigger_i,
  input  logic                           cry_edge_i,
  input  logic                           other_edge_i,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [cac_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cac_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // result requests
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           sound_alarm_on_o,
  output logic                           motor_on_o,
  output logic [1:0]                     status_o,
  output logic                           mute_mode_o,
  output logic [cac_pkg::THR_W-1:0]      threshold_now_o,
  output logic [SAMPLE_BITS-1:0]         last_level_o,
  output logic                           cry_report_o,
  output logic [TIME_BITS-1:0]           cry_time_ms_o,
  output logic [2:0]                     notice_o,
  output logic                           edge_clear_o
);
  import cac_pkg::*;

  localparam int unsigned CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int unsigned EL_W  = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;

  cac_cfg_t cfg;

  cac_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake
  logic in_vld_q, out_vld_q;
  logic out_ready, in_ready, in_accept, advance;

  assign out_ready = !out_vld_q || !out_stall_i;
  assign in_ready  = !in_vld_q || out_ready;
  assign in_accept = in_valid_i && in_ready;
  assign advance   = in_vld_q && out_ready;
  assign in_stall_o = !in_ready;

  // Input register
  logic [2:0]             op_q;
  logic [TIME_BITS-1:0]   now_q;
  logic [SAMPLE_BITS-1:0] lvl_q;
  logic                   trig_q, cry_q, oth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= opcode_i;
      now_q  <= now_ms_i;
      lvl_q  <= sound_level_i;
      trig_q <= sound_trigger_i;
      cry_q  <= cry_edge_i;
      oth_q  <= other_edge_i;
    end
  end

  // Controller state
  state_e               state_q, state_d;
  logic                 mute_q, mute_d;
  logic [THR_W-1:0]     thr_q, thr_d;
  logic [TIME_BITS-1:0] det_start_q, det_start_d;
  logic [TIME_BITS-1:0] alarm_start_q, alarm_start_d;
  logic [TIME_BITS-1:0] blink_mark_q, blink_mark_d;
  logic                 blink_q, blink_d;
  logic [TIME_BITS-1:0] cry_time_q, cry_time_d;
  logic [2:0]           notice_d;
  logic                 clear_d, report_d;

  logic [THR_W:0]       floor_sum, up_sum;
  logic [TIME_BITS-1:0] el_det, el_blink, el_alarm;

  // One poll: keys first, then the state in force after the key
  always_comb begin
    state_d       = state_q;
    mute_d        = mute_q;
    thr_d         = thr_q;
    det_start_d   = det_start_q;
    alarm_start_d = alarm_start_q;
    blink_mark_d  = blink_mark_q;
    blink_d       = blink_q;
    cry_time_d    = cry_time_q;
    notice_d      = NTC_NONE;
    clear_d       = 1'b0;
    report_d      = 1'b0;
    floor_sum     = {1'b0, cfg.thr_floor} + {1'b0, cfg.thr_incr};
    up_sum        = {1'b0, thr_q} + {1'b0, cfg.thr_incr};
    el_det        = '0;
    el_blink      = '0;
    el_alarm      = '0;

    // key handling
    case (op_q)
      OP_ENTER: begin
        mute_d   = !mute_q;
        notice_d = mute_d ? NTC_MODE_MUTE : NTC_MODE_SOUND;
        if (state_q == ST_ALARM) begin
          alarm_start_d = now_q;
          blink_mark_d  = now_q;
          blink_d       = 1'b1;
        end
      end
      OP_BACK: begin
        if (state_q == ST_ALARM) begin
          blink_d  = 1'b0;
          state_d  = ST_IDLE;
          clear_d  = 1'b1;
          notice_d = NTC_CLEARED;
        end else if (state_q == ST_DETECT) begin
          state_d = ST_IDLE;
          clear_d = 1'b1;
        end
      end
      OP_UP: begin
        // step towards the floor, clamp at the floor
        if ({1'b0, thr_q} > floor_sum) begin
          thr_d = thr_q - cfg.thr_incr;
        end else begin
          thr_d = cfg.thr_floor;
        end
      end
      OP_DOWN: begin
        // step towards the ceiling, clamp at the ceiling
        if (up_sum < {1'b0, cfg.thr_ceil}) begin
          thr_d = up_sum[THR_W-1:0];
        end else begin
          thr_d = cfg.thr_ceil;
        end
      end
      default: begin
        // no key, or an unused code
      end
    endcase

    // state update
    unique case (state_d)
      ST_IDLE: begin
        if ((CMP_W'(lvl_q) >= CMP_W'(thr_d)) || trig_q) begin
          state_d     = ST_DETECT;
          det_start_d = now_q;
          clear_d     = 1'b1;
        end
      end
      ST_DETECT: begin
        el_det = now_q - det_start_d;
        if (cry_q) begin
          cry_time_d    = now_q;
          state_d       = ST_ALARM;
          alarm_start_d = now_q;
          blink_mark_d  = now_q;
          blink_d       = 1'b1;
          report_d      = 1'b1;
        end else if (oth_q) begin
          state_d = ST_IDLE;
          clear_d = 1'b1;
        end else if (EL_W'(el_det) >= EL_W'(cfg.det_tmo)) begin
          state_d = ST_IDLE;
          clear_d = 1'b1;
        end
      end
      ST_ALARM: begin
        el_blink = now_q - blink_mark_d;
        if (EL_W'(el_blink) >= EL_W'(cfg.blink_per)) begin
          blink_mark_d = now_q;
          blink_d      = !blink_d;
        end
        if (cry_q) begin
          alarm_start_d = now_q;
          cry_time_d    = now_q;
          report_d      = 1'b1;
        end
        el_alarm = now_q - alarm_start_d;
        if (EL_W'(el_alarm) >= EL_W'(cfg.alarm_dur)) begin
          blink_d  = 1'b0;
          state_d  = ST_IDLE;
          clear_d  = 1'b1;
          notice_d = NTC_AUTO_STOP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commit the step; a write of the initial threshold reloads the live one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      mute_q        <= 1'b0;
      thr_q         <= RST_INIT_THR;
      det_start_q   <= '0;
      alarm_start_q <= '0;
      blink_mark_q  <= '0;
      blink_q       <= 1'b0;
      cry_time_q    <= '0;
    end else begin
      if (cfg_we_i && (cfg_index_i == REG_INIT_THR)) begin
        thr_q <= cfg_wdata_i[THR_W-1:0];
      end else if (advance) begin
        thr_q <= thr_d;
      end
      if (advance) begin
        state_q       <= state_d;
        mute_q        <= mute_d;
        det_start_q   <= det_start_d;
        alarm_start_q <= alarm_start_d;
        blink_mark_q  <= blink_mark_d;
        blink_q       <= blink_d;
        cry_time_q    <= cry_time_d;
      end
    end
  end

  // Result register
  logic on_d;
  assign on_d = (state_d == ST_ALARM) && blink_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sound_alarm_on_o <= on_d && !mute_d;
      motor_on_o       <= on_d && mute_d;
      status_o         <= state_d;
      mute_mode_o      <= mute_d;
      threshold_now_o  <= thr_d;
      last_level_o     <= lvl_q;
      cry_report_o     <= report_d;
      cry_time_ms_o    <= cry_time_d;
      notice_o         <= notice_d;
      edge_clear_o     <= clear_d;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

// ----- rtl/core/cac_checker.sv -----
// Port-level checks for the cry alarm controller, bound to the top level.
// Depends on cac_pkg and on the port names of cry_alarm_controller.
module cac_checker #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned TIME_BITS   = 32
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           sound_alarm_on_o,
  input logic                           motor_on_o,
  input logic [1:0]                     status_o,
  input logic                           mute_mode_o,
  input logic [cac_pkg::THR_W-1:0]      threshold_now_o,
  input logic [SAMPLE_BITS-1:0]         last_level_o,
  input logic [TIME_BITS-1:0]           cry_time_ms_o,
  input logic [2:0]                     notice_o,
  input logic                           edge_clear_o
);
  import cac_pkg::*;

  // Drives only while alarming, and the one that matches the mode
  a_drive_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sound_alarm_on_o || motor_on_o) |->
      (status_o == ST_ALARM) && (motor_on_o == mute_mode_o) &&
      (sound_alarm_on_o != mute_mode_o))
    else $error("alarm drive does not match state or mode");

  // An alarm that ends leaves alarming and flushes the detector
  a_alarm_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((notice_o == NTC_CLEARED) || (notice_o == NTC_AUTO_STOP)) |->
      (status_o != ST_ALARM) && edge_clear_o)
    else $error("alarm end while still alarming or without edge clear");

  // Mode notices agree with the reported mode
  a_mode_notice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((notice_o == NTC_MODE_MUTE) || (notice_o == NTC_MODE_SOUND)) |->
      (mute_mode_o == (notice_o == NTC_MODE_MUTE)))
    else $error("mode notice disagrees with mute mode");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(status_o) && $stable(notice_o) && $stable(cry_time_ms_o) &&
      $stable(threshold_now_o) && $stable(last_level_o))
    else $error("stalled result changed");

endmodule

bind cry_alarm_controller cac_checker #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .TIME_BITS   (TIME_BITS)
) u_cac_checker (.*);
